[hw/rtl/adsr_pkg.sv]
package adsr_pkg;

    localparam int LEN_W       = 24;
    localparam int LVL_W       = 16;
    localparam int PROD_W      = LEN_W + LVL_W;
    localparam int MUL_STEPS   = LEN_W;
    localparam int DIV_STEPS   = LVL_W;
    localparam int CNT_W       = $clog2(MUL_STEPS);
    localparam int IN_TIME_W   = 32;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam int TIME_BITS_DEF     = 32;
    localparam int EPSILON_LEVEL_DEF = 3;

    localparam logic [LEN_W-1:0] ATTACK_RST  = LEN_W'(441);
    localparam logic [LEN_W-1:0] DECAY_RST   = LEN_W'(44100);
    localparam logic [LEN_W-1:0] RELEASE_RST = LEN_W'(44100);
    localparam logic [LVL_W-1:0] PEAK_RST    = LVL_W'(32768);
    localparam logic [LVL_W-1:0] SUSTAIN_RST = LVL_W'(0);

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] n;
        logic [LVL_W-1:0] m;
        logic [LEN_W-1:0] d;
    } md_req_t;

endpackage

[hw/rtl/adsr_muldiv.sv]
module adsr_muldiv (
    input  logic                          clk,
    input  logic                          rst_n,
    input  adsr_pkg::md_req_t             req,
    output logic                          done,
    output logic [adsr_pkg::LVL_W-1:0]    quot
);

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_MUL  = 3'b010,
        M_DIV  = 3'b100
    } md_state_t;

    md_state_t                          state_reg, state_next;
    logic [adsr_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic                               done_reg, done_next;
    logic [adsr_pkg::PROD_W-1:0]        p_reg, p_next;
    logic [adsr_pkg::LVL_W-1:0]         m_reg, m_next;
    logic [adsr_pkg::LEN_W-1:0]         d_reg, d_next;

    logic [adsr_pkg::LVL_W:0]           mul_sum;
    logic [adsr_pkg::LEN_W:0]           div_shift;
    logic [adsr_pkg::LEN_W:0]           div_diff;

    // one multiplier bit per cycle, then one quotient bit per cycle
    assign mul_sum   = {1'b0, p_reg[adsr_pkg::PROD_W-1:adsr_pkg::LEN_W]} + {1'b0, m_reg};
    assign div_shift = {p_reg[adsr_pkg::PROD_W-1:adsr_pkg::LVL_W], p_reg[adsr_pkg::LVL_W-1]};
    assign div_diff  = div_shift - {1'b0, d_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        p_next     = p_reg;
        m_next     = m_reg;
        d_next     = d_reg;
        unique case (state_reg)
            M_IDLE:
            begin
                if (req.start)
                begin
                    p_next     = {{adsr_pkg::LVL_W{1'b0}}, req.n};
                    m_next     = req.m;
                    d_next     = req.d;
                    cnt_next   = adsr_pkg::CNT_W'(adsr_pkg::MUL_STEPS - 1);
                    state_next = M_MUL;
                end
            end
            M_MUL:
            begin
                if (p_reg[0])
                begin
                    p_next = {mul_sum, p_reg[adsr_pkg::LEN_W-1:1]};
                end
                else
                begin
                    p_next = {1'b0, p_reg[adsr_pkg::PROD_W-1:1]};
                end
                if (cnt_reg == '0)
                begin
                    cnt_next   = adsr_pkg::CNT_W'(adsr_pkg::DIV_STEPS - 1);
                    state_next = M_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - adsr_pkg::CNT_W'(1);
                end
            end
            M_DIV:
            begin
                if (!div_diff[adsr_pkg::LEN_W])
                begin
                    p_next = {div_diff[adsr_pkg::LEN_W-1:0],
                              p_reg[adsr_pkg::LVL_W-2:0], 1'b1};
                end
                else
                begin
                    p_next = {div_shift[adsr_pkg::LEN_W-1:0],
                              p_reg[adsr_pkg::LVL_W-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - adsr_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
        m_reg <= m_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = p_reg[adsr_pkg::LVL_W-1:0];

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == M_IDLE)
        else $error("multiply-divide started while busy");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == M_DIV |-> p_reg[adsr_pkg::PROD_W-1:adsr_pkg::LVL_W] < d_reg)
        else $error("partial remainder not below divisor");

    a_done_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == M_DIV))
        else $error("done without a division step");
`endif

endmodule

[hw/rtl/adsr_envelope_generator_core.sv]
// channel   direction  handshake              word
// in        sink       in_valid / in_stall    kind, sample_time
// out       source     out_valid / out_stall  amplitude
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// note-on, note-off and unknown words act in idle; a tick goes through diff, phase,
// decay past the attack, a wait on the serial multiply-divide for a ramp, and finish
// 24 multiply and 16 divide steps in the shared serial unit pace unstalled ramp ticks
// reset: note released, both note times zero, registers at their documented values
// a stalled result sits in the output register; the next word is still taken

module adsr_envelope_generator_core #(
    parameter int TIME_BITS     = adsr_pkg::TIME_BITS_DEF,
    parameter int EPSILON_LEVEL = adsr_pkg::EPSILON_LEVEL_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [adsr_pkg::KIND_W-1:0]       kind,
    input  logic [adsr_pkg::IN_TIME_W-1:0]    sample_time,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [adsr_pkg::LVL_W-1:0]        amplitude,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DW = (TIME_BITS > adsr_pkg::LEN_W) ? TIME_BITS : adsr_pkg::LEN_W;
    localparam logic [adsr_pkg::LVL_W-1:0] EPS = adsr_pkg::LVL_W'(EPSILON_LEVEL);

    typedef enum logic [adsr_pkg::KIND_W-1:0] {
        KIND_TICK = 2'd0,
        KIND_ON   = 2'd1,
        KIND_OFF  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [adsr_pkg::CFG_IDX_W-1:0] {
        CFG_ATTACK  = 3'd0,
        CFG_DECAY   = 3'd1,
        CFG_RELEASE = 3'd2,
        CFG_PEAK    = 3'd3,
        CFG_SUSTAIN = 3'd4
    } cfg_idx_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DIFF   = 6'b000010,
        S_PHASE  = 6'b000100,
        S_DECAY  = 6'b001000,
        S_WAIT   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        MODE_DIRECT = 2'd0,
        MODE_QUOT   = 2'd1,
        MODE_ADD    = 2'd2,
        MODE_SUB    = 2'd3
    } amp_mode_t;

    state_t                         state_reg, state_next;
    amp_mode_t                      mode_reg, mode_next;
    logic [adsr_pkg::LEN_W-1:0]     attack_reg, decay_reg, release_reg;
    logic [adsr_pkg::LVL_W-1:0]     peak_reg, sustain_reg;
    logic                           held_reg, held_next;
    logic [TIME_BITS-1:0]           on_time_reg, on_time_next;
    logic [TIME_BITS-1:0]           off_time_reg, off_time_next;
    logic [DW-1:0]                  now_reg, now_next;
    logic [DW-1:0]                  diff_reg, diff_next;
    logic                           neg_reg, neg_next;
    logic [adsr_pkg::LVL_W-1:0]     direct_reg, direct_next;
    logic                           out_valid_reg, out_valid_next;
    logic [adsr_pkg::LVL_W-1:0]     amp_reg, amp_next;

    logic [DW-1:0]                  now_w;
    logic [DW-1:0]                  base_w;
    logic                           in_take;
    logic                           out_free;
    logic [adsr_pkg::LVL_W-1:0]     amp_raw;
    adsr_pkg::md_req_t              md_req;
    logic                           md_done;
    logic [adsr_pkg::LVL_W-1:0]     md_quot;

    assign now_w    = DW'(TIME_BITS'(sample_time));
    assign base_w   = held_reg ? DW'(on_time_reg) : DW'(off_time_reg);
    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    adsr_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .done  (md_done),
        .quot  (md_quot)
    );

    always_comb
    begin
        unique case (mode_reg)
            MODE_DIRECT: amp_raw = direct_reg;
            MODE_QUOT:   amp_raw = md_quot;
            MODE_ADD:    amp_raw = peak_reg + md_quot;
            MODE_SUB:    amp_raw = peak_reg - md_quot;
            default:     amp_raw = direct_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        held_next      = held_reg;
        on_time_next   = on_time_reg;
        off_time_next  = off_time_reg;
        now_next       = now_reg;
        diff_next      = diff_reg;
        neg_next       = neg_reg;
        direct_next    = direct_reg;
        out_valid_next = out_valid_reg && out_stall;
        amp_next       = amp_reg;
        md_req         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    unique case (kind_t'(kind))
                        KIND_TICK:
                        begin
                            now_next   = now_w;
                            state_next = S_DIFF;
                        end
                        KIND_ON:
                        begin
                            on_time_next = TIME_BITS'(sample_time);
                            held_next    = 1'b1;
                        end
                        KIND_OFF:
                        begin
                            off_time_next = TIME_BITS'(sample_time);
                            held_next     = 1'b0;
                        end
                        default:
                        begin
                            held_next = held_reg;
                        end
                    endcase
                end
            end
            S_DIFF:
            begin
                neg_next   = now_reg < base_w;
                diff_next  = now_reg - base_w;
                state_next = S_PHASE;
            end
            S_PHASE:
            begin
                mode_next   = MODE_DIRECT;
                direct_next = '0;
                priority if (neg_reg)
                begin
                    state_next = S_FINISH;
                end
                else if (held_reg)
                begin
                    priority if (diff_reg == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (diff_reg <= DW'(attack_reg))
                    begin
                        md_req.start = 1'b1;
                        md_req.n     = diff_reg[adsr_pkg::LEN_W-1:0];
                        md_req.m     = peak_reg;
                        md_req.d     = attack_reg;
                        mode_next    = MODE_QUOT;
                        state_next   = S_WAIT;
                    end
                    else
                    begin
                        diff_next  = diff_reg - DW'(attack_reg);
                        state_next = S_DECAY;
                    end
                end
                else if (diff_reg >= DW'(release_reg))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    md_req.start = 1'b1;
                    md_req.n     = release_reg - diff_reg[adsr_pkg::LEN_W-1:0];
                    md_req.m     = sustain_reg;
                    md_req.d     = release_reg;
                    mode_next    = MODE_QUOT;
                    state_next   = S_WAIT;
                end
            end
            S_DECAY:
            begin
                if (diff_reg <= DW'(decay_reg))
                begin
                    md_req.start = 1'b1;
                    md_req.n     = diff_reg[adsr_pkg::LEN_W-1:0];
                    md_req.d     = decay_reg;
                    if (sustain_reg >= peak_reg)
                    begin
                        md_req.m  = sustain_reg - peak_reg;
                        mode_next = MODE_ADD;
                    end
                    else
                    begin
                        md_req.m  = peak_reg - sustain_reg;
                        mode_next = MODE_SUB;
                    end
                    state_next = S_WAIT;
                end
                else
                begin
                    mode_next   = MODE_DIRECT;
                    direct_next = sustain_reg;
                    state_next  = S_FINISH;
                end
            end
            S_WAIT:
            begin
                if (md_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    amp_next       = (amp_raw <= EPS) ? '0 : amp_raw;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= 1'b0;
            on_time_reg   <= '0;
            off_time_reg  <= '0;
            out_valid_reg <= 1'b0;
            attack_reg    <= adsr_pkg::ATTACK_RST;
            decay_reg     <= adsr_pkg::DECAY_RST;
            release_reg   <= adsr_pkg::RELEASE_RST;
            peak_reg      <= adsr_pkg::PEAK_RST;
            sustain_reg   <= adsr_pkg::SUSTAIN_RST;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            on_time_reg   <= on_time_next;
            off_time_reg  <= off_time_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_ATTACK:  attack_reg  <= cfg_data;
                    CFG_DECAY:   decay_reg   <= cfg_data;
                    CFG_RELEASE: release_reg <= cfg_data;
                    CFG_PEAK:    peak_reg    <= cfg_data[adsr_pkg::LVL_W-1:0];
                    CFG_SUSTAIN: sustain_reg <= cfg_data[adsr_pkg::LVL_W-1:0];
                    default:     attack_reg  <= attack_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        now_reg    <= now_next;
        diff_reg   <= diff_next;
        neg_reg    <= neg_next;
        direct_reg <= direct_next;
        amp_reg    <= amp_next;
    end

    assign out_valid = out_valid_reg;
    assign amplitude = amp_reg;

`ifndef SYNTHESIS
    a_eps_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (amp_reg == '0 || amp_reg > EPS))
        else $error("amplitude within the epsilon band");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> state_reg == S_WAIT)
        else $error("multiply-divide result outside the wait state");

    a_note_word_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && kind != KIND_TICK |=> state_reg == S_IDLE)
        else $error("note word started a computation");
`endif

endmodule

[dv/adsr_envelope_generator_core_tb.sv]
`timescale 1ns / 100ps

module adsr_envelope_generator_core_tb;

    typedef enum logic [adsr_pkg::KIND_W-1:0] {
        KIND_TICK,
        KIND_NOTE_ON,
        KIND_NOTE_OFF,
        KIND_UNUSED
    } kind_t;

    typedef enum logic [adsr_pkg::CFG_IDX_W-1:0] {
        REG_ATTACK,
        REG_DECAY,
        REG_RELEASE,
        REG_PEAK,
        REG_SUSTAIN,
        REG_SPARE5,
        REG_SPARE6,
        REG_SPARE7
    } reg_idx_t;

    localparam int unsigned RANDOM_WORDS = 1950;
    localparam int unsigned IDLE_PCT     = 28;
    localparam int unsigned SETTLE_CYCLES = 64;

    class envelope_scoreboard;
        logic [23:0] attack_len;
        logic [23:0] decay_len;
        logic [23:0] release_len;
        logic [15:0] peak_level;
        logic [15:0] sustain_level;
        bit          note_held;
        logic [31:0] on_time;
        logic [31:0] off_time;
        logic [15:0] amp_q[$];
        int          errors;

        function new();
            attack_len    = adsr_pkg::ATTACK_RST;
            decay_len     = adsr_pkg::DECAY_RST;
            release_len   = adsr_pkg::RELEASE_RST;
            peak_level    = adsr_pkg::PEAK_RST;
            sustain_level = adsr_pkg::SUSTAIN_RST;
            note_held     = 1'b0;
            on_time       = '0;
            off_time      = '0;
            errors        = 0;
        endfunction

        function void report(string msg);
            if (errors < 100)
                $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void write_reg(reg_idx_t idx, logic [23:0] data);
            case (idx)
                REG_ATTACK:  attack_len    = data;
                REG_DECAY:   decay_len     = data;
                REG_RELEASE: release_len   = data;
                REG_PEAK:    peak_level    = data[15:0];
                REG_SUSTAIN: sustain_level = data[15:0];
                default: ;
            endcase
        endfunction

        // updates note state, or queues the level a tick should give
        function void note_word(kind_t k, logic [31:0] t);
            longint unsigned life;
            longint unsigned u;
            longint unsigned span;
            longint unsigned lvl;
            lvl = 0;
            case (k)
                KIND_NOTE_ON:
                begin
                    on_time   = t;
                    note_held = 1'b1;
                end
                KIND_NOTE_OFF:
                begin
                    off_time  = t;
                    note_held = 1'b0;
                end
                KIND_TICK:
                begin
                    if (note_held && t >= on_time)
                    begin
                        life = t - on_time;
                        if (life <= attack_len)
                        begin
                            if (life != 0)
                                lvl = (life * peak_level) / attack_len;
                        end
                        else
                        begin
                            u = life - attack_len;
                            if (u > decay_len)
                                lvl = sustain_level;
                            else if (sustain_level >= peak_level)
                            begin
                                span = sustain_level - peak_level;
                                lvl  = peak_level + (u * span) / decay_len;
                            end
                            else
                            begin
                                span = peak_level - sustain_level;
                                lvl  = peak_level - (u * span) / decay_len;
                            end
                        end
                    end
                    else if (!note_held && t >= off_time)
                    begin
                        life = t - off_time;
                        span = release_len;
                        if (life < span)
                            lvl = (sustain_level * (span - life)) / span;
                    end
                    if (lvl <= adsr_pkg::EPSILON_LEVEL_DEF)
                        lvl = 0;
                    amp_q.push_back(lvl[15:0]);
                end
                default: ;
            endcase
        endfunction

        function void check_amplitude(logic [15:0] amp);
            logic [15:0] want;
            if (amp_q.size() == 0)
                report($sformatf("amplitude %0d with nothing pending", amp));
            else
            begin
                want = amp_q.pop_front();
                if (amp !== want)
                    report($sformatf("amplitude %0d, predicted %0d", amp, want));
            end
        endfunction
    endclass

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic [adsr_pkg::KIND_W-1:0]       kind;
    logic [adsr_pkg::IN_TIME_W-1:0]    sample_time;
    logic                              out_valid;
    logic                              out_stall;
    logic [adsr_pkg::LVL_W-1:0]        amplitude;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [adsr_pkg::CFG_DATA_W-1:0]   cfg_data;

    envelope_scoreboard sb;
    bit                 steady;
    int unsigned        words_sent;

    adsr_envelope_generator_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .sample_time (sample_time),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .amplitude   (amplitude),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_amplitude(amplitude);
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    task automatic send_word(kind_t k, logic [31:0] t);
        int unsigned gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < IDLE_PCT)
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 4);
        if (gap != 0)
        begin
            in_valid    <= 1'b0;
            kind        <= 2'($urandom);
            sample_time <= $urandom;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        sample_time <= t;
        do @(posedge clk); while (in_stall);
        sb.note_word(k, t);
        if (k != KIND_UNUSED)
            words_sent++;
    endtask

    // input held off until every pending amplitude is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.amp_q.size() != 0);
    endtask

    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [23:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    function automatic logic [23:0] pick_len();
        case ($urandom_range(0, 9))
            0: return 24'd0;
            1: return 24'd1;
            2: return 24'hFFFFFF;
            3: return 24'($urandom);
            default: return 24'($urandom_range(2, 400));
        endcase
    endfunction

    function automatic logic [23:0] pick_level();
        logic [15:0] lvl;
        logic [7:0]  junk;
        case ($urandom_range(0, 7))
            0: lvl = 16'd0;
            1: lvl = 16'd32768;
            2: lvl = 16'hFFFF;
            3: lvl = 16'($urandom);
            default: lvl = 16'($urandom_range(0, 32768));
        endcase
        junk = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0;
        return {junk, lvl};
    endfunction

    // offset from a note time, biased to the segment boundaries
    function automatic logic [31:0] pick_offset(longint unsigned a, longint unsigned b);
        longint unsigned off;
        case ($urandom_range(0, 11))
            0: off = 0;
            1: off = a;
            2: off = a + 1;
            3: off = a + b;
            4: off = a + b + 1;
            5: off = 64'(-$urandom_range(1, 50));
            6: off = $urandom;
            default: off = $urandom_range(0, 32'(a + b + b / 2 + 2));
        endcase
        return 32'(off);
    endfunction

    task automatic run_phase(int unsigned words);
        int unsigned stop_at;
        logic [31:0] base;
        logic [31:0] off_at;
        int unsigned n;
        stop_at = words_sent + words;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                base = $urandom;
                send_word(KIND_NOTE_ON, base);
                n = $urandom_range(1, 6);
                repeat (n)
                    send_word(KIND_TICK, base + pick_offset(sb.attack_len, sb.decay_len));
                off_at = base + pick_offset(sb.attack_len, sb.decay_len);
                send_word(KIND_NOTE_OFF, off_at);
                n = $urandom_range(1, 5);
                repeat (n)
                    send_word(KIND_TICK, off_at + pick_offset(0, sb.release_len));
            end
            else if ($urandom_range(0, 1) == 0)
                send_word(kind_t'($urandom_range(0, 3)), $urandom);
            else
                send_word(KIND_TICK, $urandom);
        end
    endtask

    initial
    begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int unsigned phase;
        int unsigned n;
        sb          = new();
        clk         = 1'b0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        kind        <= KIND_TICK;
        sample_time <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_ATTACK;
        cfg_data    <= '0;
        steady      = 1'b0;
        words_sent  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset values, note released
        send_word(KIND_TICK, 32'd0);
        send_word(KIND_NOTE_OFF, 32'd100);
        send_word(KIND_TICK, 32'd50);
        send_word(KIND_NOTE_ON, 32'd1000);
        send_word(KIND_TICK, 32'd999);
        send_word(KIND_TICK, 32'd1000);
        send_word(KIND_TICK, 32'd1001);
        send_word(KIND_TICK, 32'd1441);
        send_word(KIND_TICK, 32'd1442);
        send_word(KIND_TICK, 32'd45541);
        send_word(KIND_TICK, 32'hFFFFFFFF);
        send_word(KIND_UNUSED, 32'h5A5A5A5A);
        send_word(KIND_NOTE_ON, 32'd2000);
        send_word(KIND_NOTE_OFF, 32'd3000);
        send_word(KIND_TICK, 32'd3001);

        // zero lengths, full-scale levels
        settle();
        write_reg(REG_ATTACK, 24'd0);
        write_reg(REG_DECAY, 24'd0);
        write_reg(REG_RELEASE, 24'd0);
        write_reg(REG_PEAK, 24'hFFFFFF);
        write_reg(REG_SUSTAIN, 24'h00FFFF);
        write_reg(REG_SPARE5, 24'hFFFFFF);
        write_reg(REG_SPARE6, 24'h000000);
        write_reg(REG_SPARE7, 24'hA5A5A5);
        cfg_valid <= 1'b0;
        send_word(KIND_NOTE_ON, 32'h10);
        send_word(KIND_TICK, 32'h10);
        send_word(KIND_TICK, 32'h11);
        send_word(KIND_NOTE_OFF, 32'h20);
        send_word(KIND_TICK, 32'h20);

        // longest lengths, tiny peak, rising decay
        settle();
        write_reg(REG_ATTACK, 24'hFFFFFF);
        write_reg(REG_DECAY, 24'hFFFFFF);
        write_reg(REG_RELEASE, 24'hFFFFFF);
        write_reg(REG_PEAK, 24'd4);
        write_reg(REG_SUSTAIN, 24'd40000);
        cfg_valid <= 1'b0;
        send_word(KIND_NOTE_ON, 32'd0);
        send_word(KIND_TICK, 32'hFFFFFF);
        send_word(KIND_TICK, 32'hFFFFFE);
        send_word(KIND_TICK, 32'h1000000);
        send_word(KIND_NOTE_OFF, 32'hFFFFFFFF);
        send_word(KIND_TICK, 32'hFFFFFFFF);

        words_sent = 0;
        phase = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            settle();
            for (int i = 0; i <= REG_SUSTAIN; i++)
                if ($urandom_range(0, 99) < 60)
                    write_reg(reg_idx_t'(i),
                              (reg_idx_t'(i) < REG_PEAK) ? pick_len() : pick_level());
            if ($urandom_range(0, 99) < 15)
                write_reg(reg_idx_t'($urandom_range(REG_SPARE5, REG_SPARE7)), 24'($urandom));
            cfg_valid <= 1'b0;
            steady = (phase >= 6 && phase <= 8);
            n = $urandom_range(40, 120);
            run_phase(n / 2);
            if (phase % 7 == 3)
                drain_results();
            run_phase(n - n / 2);
            phase++;
        end
        steady = 1'b0;

        in_valid <= 1'b0;
        n = 0;
        while (sb.amp_q.size() != 0 && n < 100000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.amp_q.size() != 0)
            sb.report($sformatf("%0d amplitudes never arrived", sb.amp_q.size()));
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
